>>> src/zone_write_pointer_engine_defines.svh
// Assertion macros shared by the zone write pointer engine
`ifndef ZONE_WRITE_POINTER_ENGINE_DEFINES_SVH
`define ZONE_WRITE_POINTER_ENGINE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define ZWPE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ZWPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/zwpe_pkg.sv
// Types, constants and codes for the zone write pointer engine
package zwpe_pkg;

	// table geometry
	localparam int MAX_ZONES = 1024;
	localparam int ZONE_W    = 10;
	localparam int WP_W      = 21;
	localparam logic [WP_W-1:0] MAX_ZONE_SECTORS = 21'h10_0000;

	// field widths
	localparam int OP_W     = 2;
	localparam int SECTOR_W = 20;
	localparam int OFF_W    = 32;
	localparam int END_W    = OFF_W + 1;
	localparam int ADDR_W   = 48;
	localparam int ST_W     = 2;
	localparam int ZIU_W    = 11;
	localparam int SS_W     = 13;

	// datapath widths
	localparam int MUL_A_W = ZONE_W + WP_W;
	localparam int PROD_W  = MUL_A_W + SS_W;
	localparam int CAPB_W  = WP_W + SS_W;
	localparam int NEXT_W  = END_W + 1;

	// divider sequencing
	localparam int DIV_STEPS = END_W;
	localparam int CNT_W     = 6;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 21;
	localparam logic [CFG_IDX_W-1:0] CFG_ZONES_IN_USE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ZONE_CAP     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_SIZE  = 2'd2;

	localparam logic [ZIU_W-1:0] RST_ZONES_IN_USE = 11'd1024;
	localparam logic [WP_W-1:0]  RST_ZONE_CAP     = 21'd65536;
	localparam logic [SS_W-1:0]  RST_SECTOR_SIZE  = 13'd512;

	// request codes
	localparam logic [OP_W-1:0] OP_READ   = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_RESET  = 2'd2;

	// result status codes
	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE     = 2'd1;
	localparam logic [ST_W-1:0] ST_UNWRITTEN = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic [ZIU_W-1:0] zones_in_use;
		logic [WP_W-1:0]  zone_capacity_sectors;
		logic [SS_W-1:0]  sector_size_bytes;
	} zwpe_cfg_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOKUP,
		S_MUL_CAPSS,
		S_MUL_ZCAP,
		S_MUL_BASE,
		S_MUL_SEC,
		S_ADD_BASE,
		S_ADD_OFF,
		S_DIV,
		S_FINISH
	} zwpe_state_t;

	typedef enum logic [1:0] {
		MS_CAPSS,
		MS_ZCAP,
		MS_BASE,
		MS_SEC
	} mul_sel_t;

	// controller to datapath
	typedef struct packed {
		logic     clr_step;
		logic     capture;
		logic     wp_read;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     add_base;
		logic     add_off;
		logic     div_init;
		logic     div_step;
		logic     finish;
	} zwpe_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic is_append;
		logic out_free;
	} zwpe_sts_t;

endpackage

>>> src/zwpe_if.sv
// Request and result channel interfaces of the zone write pointer engine
interface zwpe_req_if;
	import zwpe_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [ZONE_W-1:0]   zone;
	logic [SECTOR_W-1:0] sector;
	logic [OFF_W-1:0]    byte_offset;
	logic [OFF_W-1:0]    length;

	modport source (output valid, op, zone, sector, byte_offset, length, input ready);
	modport sink (input valid, op, zone, sector, byte_offset, length, output ready);
endinterface

interface zwpe_res_if;
	import zwpe_pkg::*;

	logic              valid;
	logic              ready;
	logic [ST_W-1:0]   status;
	logic [ADDR_W-1:0] byte_address;
	logic [WP_W-1:0]   assigned_sector;

	modport source (output valid, status, byte_address, assigned_sector, input ready);
	modport sink (input valid, status, byte_address, assigned_sector, output ready);
endinterface

>>> src/zwpe_ctrl.sv
// Sequencing state machine of the zone write pointer engine
module zwpe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output zwpe_pkg::zwpe_cmd_t cmd,
	input  zwpe_pkg::zwpe_sts_t sts
);
	import zwpe_pkg::*;

	zwpe_state_t      state_q;
	zwpe_state_t      state_nxt;
	logic [CNT_W-1:0] cnt_q;

	// state register and divider step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_ADD_OFF) begin
				cnt_q <= CNT_W'(DIV_STEPS - 1);
			end else if (state_q == S_DIV) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR:     if (sts.clr_last) state_nxt = S_IDLE;
			S_IDLE:      if (in_valid) state_nxt = S_LOOKUP;
			S_LOOKUP:    state_nxt = S_MUL_CAPSS;
			S_MUL_CAPSS: state_nxt = S_MUL_ZCAP;
			S_MUL_ZCAP:  state_nxt = S_MUL_BASE;
			S_MUL_BASE:  state_nxt = S_MUL_SEC;
			S_MUL_SEC:   state_nxt = S_ADD_BASE;
			S_ADD_BASE:  state_nxt = S_ADD_OFF;
			S_ADD_OFF:   state_nxt = sts.is_append ? S_DIV : S_FINISH;
			S_DIV:       if (cnt_q == '0) state_nxt = S_FINISH;
			S_FINISH:    if (sts.out_free) state_nxt = S_IDLE;
			default:     state_nxt = S_CLEAR;
		endcase
	end

	// commands
	always_comb begin
		cmd         = '0;
		cmd.mul_sel = MS_CAPSS;
		in_ready    = 1'b0;
		unique case (state_q)
			S_CLEAR: cmd.clr_step = 1'b1;
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_LOOKUP: cmd.wp_read = 1'b1;
			S_MUL_CAPSS: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_CAPSS;
			end
			S_MUL_ZCAP: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_ZCAP;
			end
			S_MUL_BASE: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_BASE;
			end
			S_MUL_SEC: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_SEC;
			end
			S_ADD_BASE: cmd.add_base = 1'b1;
			S_ADD_OFF: begin
				cmd.add_off  = 1'b1;
				cmd.div_init = 1'b1;
			end
			S_DIV:    cmd.div_step = 1'b1;
			S_FINISH: cmd.finish = sts.out_free;
			default:  cmd = '0;
		endcase
	end

endmodule

>>> src/zwpe_dp.sv
// Datapath: write pointer table, shared multiplier, divider and result register
module zwpe_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  zwpe_pkg::zwpe_cfg_t cfg,
	input  zwpe_pkg::zwpe_cmd_t cmd,
	output zwpe_pkg::zwpe_sts_t sts,
	zwpe_req_if.sink            req,
	zwpe_res_if.source          res
);
	import zwpe_pkg::*;

	// write pointer table
	logic [WP_W-1:0]   wpt_mem [MAX_ZONES];
	logic [ZONE_W-1:0] clr_addr_q;
	logic              mem_we;
	logic [ZONE_W-1:0] mem_waddr;
	logic [WP_W-1:0]   mem_wdata;

	// captured request
	logic [OP_W-1:0]     op_q;
	logic [ZONE_W-1:0]   zone_q;
	logic [SECTOR_W-1:0] sector_q;
	logic [OFF_W-1:0]    off_q;
	logic [END_W-1:0]    end_q;
	logic [WP_W-1:0]     wp_q;

	// products and sums
	logic [MUL_A_W-1:0] mul_a;
	logic [SS_W-1:0]    mul_b;
	logic [PROD_W-1:0]  prod;
	logic [CAPB_W-1:0]  capb_q;
	logic [MUL_A_W-1:0] zc_q;
	logic [PROD_W-1:0]  base_q;
	logic [CAPB_W-1:0]  secb_q;
	logic [ADDR_W-1:0]  addr_q;

	// divider
	logic [END_W-1:0] dq_q;
	logic [SS_W-1:0]  rem_q;
	logic [SS_W:0]    trial;
	logic             q_bit;

	// effective configuration
	logic [WP_W-1:0] cap_eff;
	logic [SS_W-1:0] ss_eff;

	// result register
	logic              res_valid_q;
	logic [ST_W-1:0]   res_status_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [WP_W-1:0]   res_asec_q;

	// finish decisions
	logic              zone_ok;
	logic              end_ok;
	logic [NEXT_W-1:0] next_wp;
	logic [ST_W-1:0]   fin_status;
	logic [ADDR_W-1:0] fin_addr;
	logic [WP_W-1:0]   fin_asec;
	logic              fin_wr;
	logic [WP_W-1:0]   fin_wdata;

	// capacity clamps to the table limit, a zero sector size acts as one
	assign cap_eff = (cfg.zone_capacity_sectors > MAX_ZONE_SECTORS) ?
		MAX_ZONE_SECTORS : cfg.zone_capacity_sectors;
	assign ss_eff  = (cfg.sector_size_bytes == '0) ? SS_W'(1) : cfg.sector_size_bytes;

	// shared multiplier operand select
	always_comb begin
		mul_a = MUL_A_W'(cap_eff);
		mul_b = ss_eff;
		case (cmd.mul_sel)
			MS_CAPSS: begin
				mul_a = MUL_A_W'(cap_eff);
				mul_b = ss_eff;
			end
			MS_ZCAP: begin
				mul_a = MUL_A_W'(cap_eff);
				mul_b = SS_W'(zone_q);
			end
			MS_BASE: begin
				mul_a = zc_q;
				mul_b = ss_eff;
			end
			MS_SEC: begin
				mul_a = (op_q == OP_READ) ? MUL_A_W'(sector_q) : MUL_A_W'(wp_q);
				mul_b = ss_eff;
			end
			default: mul_a = MUL_A_W'(cap_eff);
		endcase
	end

	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

	// restoring divider step: one quotient bit per cycle
	assign trial = {rem_q, dq_q[END_W-1]};
	assign q_bit = (trial >= {1'b0, ss_eff});

	// range checks and result selection
	assign zone_ok = ({1'b0, zone_q} < cfg.zones_in_use);
	assign end_ok  = ({1'b0, end_q} <= capb_q);
	assign next_wp = NEXT_W'(wp_q) + NEXT_W'(dq_q) + NEXT_W'(rem_q != '0);

	always_comb begin
		fin_status = ST_RANGE;
		fin_addr   = '0;
		fin_asec   = '0;
		fin_wr     = 1'b0;
		fin_wdata  = '0;
		unique case (op_q)
			OP_READ: begin
				if (zone_ok && (WP_W'(sector_q) <= cap_eff) && end_ok) begin
					if (wp_q <= WP_W'(sector_q)) begin
						fin_status = ST_UNWRITTEN;
					end else begin
						fin_status = ST_OK;
						fin_addr   = addr_q;
					end
				end
			end
			OP_APPEND: begin
				if (zone_ok && (wp_q <= cap_eff) && end_ok) begin
					if (next_wp > NEXT_W'(cap_eff)) begin
						fin_status = ST_FULL;
					end else begin
						fin_status = ST_OK;
						fin_addr   = addr_q;
						fin_asec   = wp_q;
						fin_wr     = 1'b1;
						fin_wdata  = next_wp[WP_W-1:0];
					end
				end
			end
			OP_RESET: begin
				if (zone_ok) begin
					fin_status = ST_OK;
					fin_addr   = ADDR_W'(base_q);
					fin_wr     = 1'b1;
				end
			end
			default: fin_status = ST_RANGE;
		endcase
	end

	// table write port: clearing sweep or pointer update
	assign mem_we    = cmd.clr_step | (cmd.finish & fin_wr);
	assign mem_waddr = cmd.clr_step ? clr_addr_q : zone_q;
	assign mem_wdata = cmd.clr_step ? '0 : fin_wdata;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			wpt_mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.wp_read) begin
			wp_q <= wpt_mem[zone_q];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (cmd.finish) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= req.op;
			zone_q   <= req.zone;
			sector_q <= req.sector;
			off_q    <= req.byte_offset;
			end_q    <= END_W'(req.byte_offset) + END_W'(req.length);
		end
		if (cmd.mul_en) begin
			case (cmd.mul_sel)
				MS_CAPSS: capb_q <= prod[CAPB_W-1:0];
				MS_ZCAP:  zc_q   <= prod[MUL_A_W-1:0];
				MS_BASE:  base_q <= prod;
				MS_SEC:   secb_q <= prod[CAPB_W-1:0];
				default:  capb_q <= prod[CAPB_W-1:0];
			endcase
		end
		if (cmd.add_base) begin
			addr_q <= ADDR_W'(base_q) + ADDR_W'(secb_q);
		end else if (cmd.add_off) begin
			addr_q <= addr_q + ADDR_W'(off_q);
		end
		if (cmd.div_init) begin
			dq_q  <= end_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dq_q  <= {dq_q[END_W-2:0], q_bit};
			rem_q <= q_bit ? SS_W'(trial - {1'b0, ss_eff}) : trial[SS_W-1:0];
		end
		if (cmd.finish) begin
			res_status_q <= fin_status;
			res_addr_q   <= fin_addr;
			res_asec_q   <= fin_asec;
		end
	end

	// status back to the controller
	assign sts.clr_last  = (clr_addr_q == '1);
	assign sts.is_append = (op_q == OP_APPEND);
	assign sts.out_free  = !res_valid_q || res.ready;

	assign res.valid           = res_valid_q;
	assign res.status          = res_status_q;
	assign res.byte_address    = res_addr_q;
	assign res.assigned_sector = res_asec_q;

endmodule

>>> src/zone_write_pointer_engine.sv
// Top level of the zone write pointer engine: configuration registers and wiring
//
// Keeps one 21-bit write pointer per zone for a zoned namespace. Requests come
// in on req (op, zone, sector, byte_offset, length): read, append or zone
// reset. Each request gives exactly one item on res (status, byte_address,
// assigned_sector). Configuration goes through cfg_we / cfg_idx / cfg_data:
// index 0 zones in use, 1 zone capacity in sectors, 2 sector size in bytes.
// Items are handled one at a time. A read or zone reset goes through lookup,
// the multiplies and the address adds; an append also runs the bit-serial
// divider that computes the pointer advance, one quotient bit per cycle over
// 33 bits. The engine is ready for the next item in the same cycle that the
// result becomes valid. Address products come from one shared 31x13
// multiplier, used in turn for capacity bytes, zone base sector, zone base
// bytes and sector bytes. After reset the engine sweeps all 1024 pointer
// table entries to zero, one entry a cycle, with req.ready low; configuration
// is reset to 1024 zones, 65536 sectors and 512 bytes. The result sits in an
// output register; while res.ready stays low the engine holds it and can take
// one more item, whose result then waits until the register is free.
`include "zone_write_pointer_engine_defines.svh"

module zone_write_pointer_engine (
	input  logic                             clk,
	input  logic                             arst_n,
	zwpe_req_if.sink                         req,
	zwpe_res_if.source                       res,
	input  logic                             cfg_we,
	input  logic [zwpe_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [zwpe_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import zwpe_pkg::*;

	logic [ZIU_W-1:0] zones_in_use_q;
	logic [WP_W-1:0]  zone_cap_q;
	logic [SS_W-1:0]  sector_size_q;
	zwpe_cfg_t        cfg;
	zwpe_cmd_t        cmd;
	zwpe_sts_t        sts;
	logic             in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zones_in_use_q <= RST_ZONES_IN_USE;
			zone_cap_q     <= RST_ZONE_CAP;
			sector_size_q  <= RST_SECTOR_SIZE;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_ZONES_IN_USE: zones_in_use_q <= cfg_data[ZIU_W-1:0];
				CFG_ZONE_CAP:     zone_cap_q     <= cfg_data[WP_W-1:0];
				CFG_SECTOR_SIZE:  sector_size_q  <= cfg_data[SS_W-1:0];
				default:          zones_in_use_q <= zones_in_use_q;
			endcase
		end
	end

	assign cfg.zones_in_use          = zones_in_use_q;
	assign cfg.zone_capacity_sectors = zone_cap_q;
	assign cfg.sector_size_bytes     = sector_size_q;

	assign req.ready = in_ready;

	zwpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	zwpe_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts),
		.req    (req),
		.res    (res)
	);

	// one item in flight: the engine goes busy right after taking an item
	`ZWPE_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready, !req.ready, "item accepted while busy")
	// a finished item never overwrites a result still waiting
	`ZWPE_ASSERT_SAME(a_no_overwrite, clk, arst_n, cmd.finish, !res.valid || res.ready, "result overwritten before taken")
	// a result appears only from a finish step
	`ZWPE_ASSERT_SAME(a_valid_from_finish, clk, arst_n, $rose(res.valid), $past(cmd.finish), "result valid without finish")

endmodule

>>> dv/tb_zone_write_pointer_engine.sv
// Self-checking testbench for the zone write pointer engine
`timescale 1ns / 1ps

module tb_zone_write_pointer_engine;
	import zwpe_pkg::*;

	// op code with no meaning, answered as out of range
	localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;
	localparam int SETTLE_CYCLES = 50;
	localparam int HOLD_OFF_CYCLES = 400;

	typedef struct {
		logic [OP_W-1:0]     op;
		logic [ZONE_W-1:0]   zone;
		logic [SECTOR_W-1:0] sector;
		logic [OFF_W-1:0]    byte_offset;
		logic [OFF_W-1:0]    length;
	} zone_request_t;

	typedef struct {
		logic [ST_W-1:0]   status;
		logic [ADDR_W-1:0] byte_address;
		logic [WP_W-1:0]   assigned_sector;
	} zone_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	zwpe_req_if req_ch();
	zwpe_res_if res_ch();

	zone_write_pointer_engine uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.res      (res_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// shadow of the engine: geometry registers and pointer table
	logic [ZIU_W-1:0] cfg_zones_in_use;
	logic [WP_W-1:0]  cfg_zone_cap;
	logic [SS_W-1:0]  cfg_sector_size;
	logic [WP_W-1:0]  wp_table [MAX_ZONES];

	zone_request_t pending_requests[$];
	zone_result_t  expected_results[$];
	zone_result_t  oldest_result;
	zone_request_t next_request;

	int  mismatches;
	int  results_seen;
	int  send_gap;
	int  recv_gap;
	bit  steady_flow;
	logic hold_long;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [63:0] effective_capacity();
		return (cfg_zone_cap > MAX_ZONE_SECTORS) ? 64'(MAX_ZONE_SECTORS) : 64'(cfg_zone_cap);
	endfunction

	function automatic logic [63:0] effective_sector_size();
		return (cfg_sector_size == '0) ? 64'd1 : 64'(cfg_sector_size);
	endfunction

	function automatic logic [ADDR_W-1:0] flat_address(input logic [63:0] zone, sector, offset);
		logic [63:0] ss;
		ss = effective_sector_size();
		return ADDR_W'(zone * effective_capacity() * ss + sector * ss + offset);
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int roll;
		if (steady_flow)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got, want);
		if (mismatches < 40)
			$display("%0t mismatch: %s got 0x%0h want 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	// work out the result of one accepted request and update the pointer table
	task automatic predict_request(input logic [OP_W-1:0] op, input logic [ZONE_W-1:0] zone,
		input logic [SECTOR_W-1:0] sector, input logic [OFF_W-1:0] offset,
		input logic [OFF_W-1:0] length);
		zone_result_t rs;
		logic [63:0] cap, ss, span_end, wp, next_wp;
		bit zone_live;
		cap = effective_capacity();
		ss = effective_sector_size();
		span_end = 64'(offset) + 64'(length);
		zone_live = 64'(zone) < 64'(cfg_zones_in_use);
		wp = 64'(wp_table[zone]);
		rs.status = ST_RANGE;
		rs.byte_address = '0;
		rs.assigned_sector = '0;
		case (op)
		OP_READ: begin
			if (zone_live && 64'(sector) <= cap && span_end <= cap * ss) begin
				if (wp <= 64'(sector)) begin
					rs.status = ST_UNWRITTEN;
				end else begin
					rs.status = ST_OK;
					rs.byte_address = flat_address(zone, sector, offset);
				end
			end
		end
		OP_APPEND: begin
			// the append lands at the write pointer
			if (zone_live && wp <= cap && span_end <= cap * ss) begin
				next_wp = wp + span_end / ss + ((span_end % ss) != 0 ? 64'd1 : 64'd0);
				if (next_wp > cap) begin
					rs.status = ST_FULL;
				end else begin
					rs.status = ST_OK;
					rs.byte_address = flat_address(zone, wp, offset);
					rs.assigned_sector = WP_W'(wp);
					wp_table[zone] = WP_W'(next_wp);
				end
			end
		end
		OP_RESET: begin
			if (zone_live) begin
				rs.status = ST_OK;
				rs.byte_address = flat_address(zone, 0, 0);
				wp_table[zone] = '0;
			end
		end
		default: ;
		endcase
		expected_results.push_back(rs);
	endtask

	task automatic add_request(input logic [OP_W-1:0] op, input int unsigned zone, sector,
		input logic [OFF_W-1:0] offset, length);
		zone_request_t rq;
		rq.op = op;
		rq.zone = ZONE_W'(zone);
		rq.sector = SECTOR_W'(sector);
		rq.byte_offset = offset;
		rq.length = length;
		pending_requests.push_back(rq);
	endtask

	// random requests shaped by the current geometry: appends and reads on a
	// few busy zones so pointers grow, plus resets, stray zones and raw noise
	task automatic queue_random_requests(input int count);
		zone_request_t rq;
		int unsigned live, cap, ss, roll, zone_pick;
		live = (cfg_zones_in_use > MAX_ZONES) ? MAX_ZONES : cfg_zones_in_use;
		cap = effective_capacity();
		ss = effective_sector_size();
		repeat (count) begin
			roll = $urandom_range(0, 99);
			if (live == 0)
				zone_pick = $urandom_range(0, MAX_ZONES - 1);
			else if ($urandom_range(0, 3) != 0)
				zone_pick = $urandom_range(0, ((live < 4) ? live : 4) - 1);
			else
				zone_pick = $urandom_range(0, live - 1);
			rq.zone = ZONE_W'(zone_pick);
			rq.sector = SECTOR_W'($urandom_range(0, 40));
			rq.byte_offset = $urandom_range(0, 2 * ss);
			rq.length = $urandom_range(0, 3 * ss);
			rq.op = OP_APPEND;
			if (roll < 10) begin
				rq.op = OP_W'($urandom_range(0, 3));
				rq.zone = ZONE_W'($urandom);
				rq.sector = SECTOR_W'($urandom);
				rq.byte_offset = $urandom;
				rq.length = $urandom;
			end else if (roll < 50) begin
				if ($urandom_range(0, 7) == 0)
					rq.length = $urandom;
			end else if (roll < 80) begin
				rq.op = OP_READ;
				if ($urandom_range(0, 7) == 0)
					rq.sector = (cap < 32'hFFFFF) ? SECTOR_W'(cap + $urandom_range(0, 1)) : '1;
			end else if (roll < 92) begin
				rq.op = OP_RESET;
			end else begin
				// zone outside the namespace, or any zone if all zones are in use
				rq.op = OP_W'($urandom_range(0, 2));
				rq.zone = (live < MAX_ZONES) ? ZONE_W'($urandom_range(live, MAX_ZONES - 1))
					: ZONE_W'($urandom);
			end
			pending_requests.push_back(rq);
		end
	endtask

	task automatic program_geometry(input int unsigned zones, cap, ss);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_ZONES_IN_USE;
		cfg_data <= CFG_DATA_W'(zones);
		@(posedge clk);
		cfg_idx <= CFG_ZONE_CAP;
		cfg_data <= CFG_DATA_W'(cap);
		@(posedge clk);
		cfg_idx <= CFG_SECTOR_SIZE;
		cfg_data <= CFG_DATA_W'(ss);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// wait until every request is answered, then let the engine go quiet
	task automatic settle();
		@(negedge clk);
		while (pending_requests.size() != 0 || req_ch.valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// geometry mirror, follows the write port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_zones_in_use <= RST_ZONES_IN_USE;
			cfg_zone_cap <= RST_ZONE_CAP;
			cfg_sector_size <= RST_SECTOR_SIZE;
		end else if (cfg_we) begin
			case (cfg_idx)
			CFG_ZONES_IN_USE: cfg_zones_in_use <= cfg_data[ZIU_W-1:0];
			CFG_ZONE_CAP: cfg_zone_cap <= cfg_data[WP_W-1:0];
			CFG_SECTOR_SIZE: cfg_sector_size <= cfg_data[SS_W-1:0];
			default: ;
			endcase
		end
	end

	// request driver: predicts on acceptance, then offers the next item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			send_gap = 0;
			for (int i = 0; i < MAX_ZONES; i++)
				wp_table[i] = '0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				predict_request(req_ch.op, req_ch.zone, req_ch.sector, req_ch.byte_offset,
					req_ch.length);
			if (!req_ch.valid || req_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req_ch.valid <= 1'b0;
				end else if (pending_requests.size() != 0) begin
					next_request = pending_requests.pop_front();
					req_ch.op <= next_request.op;
					req_ch.zone <= next_request.zone;
					req_ch.sector <= next_request.sector;
					req_ch.byte_offset <= next_request.byte_offset;
					req_ch.length <= next_request.length;
					req_ch.valid <= 1'b1;
					send_gap = pick_gap();
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: checks each item against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with none expected", res_ch.status, 0);
				end else begin
					oldest_result = expected_results.pop_front();
					if (res_ch.status !== oldest_result.status)
						report_mismatch("status", res_ch.status, oldest_result.status);
					if (res_ch.byte_address !== oldest_result.byte_address)
						report_mismatch("byte_address", res_ch.byte_address,
							oldest_result.byte_address);
					if (res_ch.assigned_sector !== oldest_result.assigned_sector)
						report_mismatch("assigned_sector", res_ch.assigned_sector,
							oldest_result.assigned_sector);
				end
				results_seen++;
				recv_gap = pick_gap();
			end else if (recv_gap == 0 && !steady_flow && $urandom_range(0, 19) == 0) begin
				recv_gap = pick_gap();
			end
			if (hold_long || recv_gap > 0) begin
				res_ch.ready <= 1'b0;
				if (recv_gap > 0)
					recv_gap--;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// one long receiver hold-off while requests keep coming
	initial begin
		hold_long = 1'b0;
		wait (results_seen >= 60);
		@(posedge clk);
		hold_long <= 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		hold_long <= 1'b0;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// stimulus sequence
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_ZONES_IN_USE;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_READ;
		req_ch.zone = '0;
		req_ch.sector = '0;
		req_ch.byte_offset = '0;
		req_ch.length = '0;
		res_ch.ready = 1'b0;
		mismatches = 0;
		results_seen = 0;
		steady_flow = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset geometry: 1024 zones, 65536 sectors of 512 bytes
		add_request(OP_READ, 0, 0, 0, 0);               // nothing written yet
		add_request(OP_APPEND, 0, 0, 0, 0);             // empty append, pointer stays
		add_request(OP_APPEND, 0, 0, 0, 1);
		add_request(OP_READ, 0, 0, 0, 0);
		add_request(OP_READ, 0, 1, 0, 0);               // exactly at the pointer
		add_request(OP_APPEND, 0, 7, 100, 512);         // partial sector rounds up
		add_request(OP_APPEND, 0, 0, 0, 32'd33552896);  // fills the zone exactly
		add_request(OP_APPEND, 0, 0, 0, 1);             // zone full
		add_request(OP_READ, 0, 65536, 0, 0);           // sector equal to capacity
		add_request(OP_READ, 0, 65537, 0, 0);           // past capacity
		add_request(OP_READ, 0, 20'hFFFFF, '1, '1);
		add_request(OP_READ, 0, 100, 0, 32'd33554432);  // span ends at zone end
		add_request(OP_READ, 0, 100, 1, 32'd33554432);  // one byte over
		add_request(OP_RESET, 0, 0, 0, 0);
		add_request(OP_READ, 0, 0, 0, 0);
		add_request(OP_APPEND, 1023, 0, 511, 1);
		add_request(OP_READ, 1023, 0, 511, 0);
		add_request(OP_APPEND, 1023, 0, '1, 0);
		add_request(OP_UNDEFINED, 5, 3, 0, 0);
		add_request(OP_RESET, 1023, 20'hFFFFF, '1, '1);
		add_request(OP_APPEND, 10'h2AA, 20'hAAAAA, 0, '1);
		add_request(OP_READ, 10'h155, 20'h55555, 32'hAAAAAAAA, 32'h55555555);
		queue_random_requests(150);
		settle();

		// small zones that fill up quickly
		program_geometry(8, 40, 512);
		queue_random_requests(150);
		settle();

		// smallest geometry, no idling
		steady_flow = 1'b1;
		program_geometry(1, 1, 1);
		queue_random_requests(80);
		settle();
		steady_flow = 1'b0;

		// all register fields at their top, capacity above the table limit
		program_geometry(2047, 2097151, 8191);
		queue_random_requests(100);
		settle();

		// no zones in use: everything is out of range
		program_geometry(0, 65536, 512);
		add_request(OP_RESET, 0, 0, 0, 0);
		add_request(OP_APPEND, 0, 0, 0, 0);
		add_request(OP_READ, 0, 0, 0, 0);
		queue_random_requests(30);
		settle();

		// zero sector size acts as one byte, full table capacity, no idling
		steady_flow = 1'b1;
		program_geometry(1024, 1048576, 0);
		queue_random_requests(100);
		settle();
		steady_flow = 1'b0;

		program_geometry(16, 200, 4096);
		queue_random_requests(120);
		settle();

		// odd sector size
		program_geometry(5, 50, 3);
		queue_random_requests(120);
		settle();

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
